FILE: hdl/qslerp_pkg.sv
// types, constants and the arctangent table for the quaternion slerp unit
// no dependencies; used by quaternion_slerp_unit
package qslerp_pkg;

    typedef struct packed {
        logic [15:0] a_x;
        logic [15:0] a_y;
        logic [15:0] a_z;
        logic [15:0] a_w;
        logic [15:0] b_x;
        logic [15:0] b_y;
        logic [15:0] b_z;
        logic [15:0] b_w;
        logic [15:0] blend;
    } in_t;

    typedef struct packed {
        logic [15:0] out_x;
        logic [15:0] out_y;
        logic [15:0] out_z;
        logic [15:0] out_w;
        logic        passed_through;
    } out_t;

    localparam int          TABLE_LEN       = 32;
    localparam logic [30:0] ONE_Q30         = 31'd1 << 30;
    localparam logic [31:0] RATIO_LIMIT     = 32'd1 << 31;
    localparam logic [29:0] CORDIC_GAIN_INV = 30'd652032874;
    localparam logic [15:0] BLEND_ONE       = 16'd32768;

    // arctangent of 2^-i, radians in Q30, truncated
    function automatic logic [29:0] atan_q30(input int i);
        logic [29:0] v;
        v = '0;
        unique case (i)
            0:  v = 30'd843314856;
            1:  v = 30'd497837829;
            2:  v = 30'd263043836;
            3:  v = 30'd133525158;
            4:  v = 30'd67021686;
            5:  v = 30'd33543515;
            6:  v = 30'd16775850;
            7:  v = 30'd8388437;
            8:  v = 30'd4194282;
            9:  v = 30'd2097149;
            10: v = 30'd1048575;
            11: v = 30'd524287;
            12: v = 30'd262143;
            13: v = 30'd131071;
            14: v = 30'd65535;
            15: v = 30'd32767;
            16: v = 30'd16383;
            17: v = 30'd8191;
            18: v = 30'd4095;
            19: v = 30'd2047;
            20: v = 30'd1023;
            21: v = 30'd511;
            22: v = 30'd255;
            23: v = 30'd127;
            24: v = 30'd63;
            25: v = 30'd31;
            26: v = 30'd15;
            27: v = 30'd7;
            28: v = 30'd3;
            29: v = 30'd1;
            default: v = 30'd0;
        endcase
        return v;
    endfunction

endpackage

FILE: hdl/quaternion_slerp_unit.sv
// quaternion spherical linear interpolation, fully pipelined
// depends on qslerp_pkg
//
// One request is taken in every cycle (busy stays low) and its result appears
// on result with done high for one cycle. Most of the pipeline's length lies
// in the bit-per-stage square root (31 stages), the two CORDIC chains (one
// stage per step) and the bit-per-stage ratio dividers (32 stages). Results
// leave in request order and cannot be held off, so the receiver must take
// every done beat.
module quaternion_slerp_unit #(
    parameter int FRAC_BITS    = 14,
    parameter int CORDIC_STEPS = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  qslerp_pkg::in_t    request,
    output logic               done,
    output qslerp_pkg::out_t   result
);

    localparam int NSTEP =
        (CORDIC_STEPS < qslerp_pkg::TABLE_LEN) ? CORDIC_STEPS : qslerp_pkg::TABLE_LEN;
    localparam logic [63:0] ONE_DOT   = 64'd1 << (2 * FRAC_BITS);
    localparam bit          DOT_WIDE  = (2 * FRAC_BITS >= 30);
    localparam int          DOT_SHIFT = DOT_WIDE ? (2 * FRAC_BITS - 30) : (30 - 2 * FRAC_BITS);
    localparam int          SQ_N      = 31;
    localparam int          DIV_N     = 32;

    typedef struct packed {
        logic             pass;
        logic [3:0][15:0] a;
        logic [3:0][16:0] b;
        logic [15:0]      t;
    } ctx_t;

    assign busy = 1'b0;

    // ---------------- input register ----------------
    logic in_v_reg;
    ctx_t in_ctx_reg, in_ctx_next;

    always_comb
    begin
        in_ctx_next.pass = 1'b0;
        in_ctx_next.a[0] = request.a_x;
        in_ctx_next.a[1] = request.a_y;
        in_ctx_next.a[2] = request.a_z;
        in_ctx_next.a[3] = request.a_w;
        in_ctx_next.b[0] = {request.b_x[15], request.b_x};
        in_ctx_next.b[1] = {request.b_y[15], request.b_y};
        in_ctx_next.b[2] = {request.b_z[15], request.b_z};
        in_ctx_next.b[3] = {request.b_w[15], request.b_w};
        in_ctx_next.t = (request.blend > qslerp_pkg::BLEND_ONE) ?
                        qslerp_pkg::BLEND_ONE : request.blend;
    end

    // ---------------- component products ----------------
    logic               p1_v_reg;
    ctx_t               p1_ctx_reg;
    logic signed [31:0] p1_prod_reg [4];

    // ---------------- dot, sign fold, pass test ----------------
    logic        p2_v_reg;
    ctx_t        p2_ctx_reg, p2_ctx_next;
    logic [29:0] p2_c30_reg, p2_c30_next;
    logic signed [33:0] dot;
    logic [33:0] dot_abs;
    logic [63:0] dot_wide;

    always_comb
    begin
        dot = 34'(p1_prod_reg[0]) + 34'(p1_prod_reg[1])
            + 34'(p1_prod_reg[2]) + 34'(p1_prod_reg[3]);
        dot_abs = dot[33] ? 34'(-dot) : 34'(dot);
        p2_ctx_next = p1_ctx_reg;
        for (int k = 0; k < 4; k++)
        begin
            if (dot[33])
                p2_ctx_next.b[k] = 17'(-$signed(p1_ctx_reg.b[k]));
        end
        p2_ctx_next.pass = ({30'd0, dot_abs} >= ONE_DOT);
        dot_wide = DOT_WIDE ? ({30'd0, dot_abs} >> DOT_SHIFT)
                            : ({30'd0, dot_abs} << DOT_SHIFT);
        p2_c30_next = dot_wide[29:0];
    end

    // ---------------- cosine squared ----------------
    logic        p3_v_reg;
    ctx_t        p3_ctx_reg;
    logic [29:0] p3_c30_reg;
    logic [59:0] p3_sq_reg;

    // ---------------- square root, one result bit per stage ----------------
    logic        sq_v_reg    [SQ_N];
    ctx_t        sq_ctx_reg  [SQ_N];
    logic [29:0] sq_c30_reg  [SQ_N];
    logic [60:0] sq_rem_reg  [SQ_N];
    logic [61:0] sq_root_reg [SQ_N];
    logic [60:0] sq_rem_next [SQ_N];
    logic [61:0] sq_root_next[SQ_N];

    for (genvar k = 0; k < SQ_N; k++)
    begin : g_sqrt
        logic [60:0] rem_in;
        logic [61:0] root_in;
        logic [61:0] trial;
        logic [61:0] bitv;
        always_comb
        begin
            bitv = 62'd1 << (60 - 2 * k);
            if (k == 0)
            begin
                rem_in  = (61'd1 << 60) - {1'b0, p3_sq_reg};
                root_in = '0;
            end
            else
            begin
                rem_in  = sq_rem_reg[(k == 0) ? 0 : k - 1];
                root_in = sq_root_reg[(k == 0) ? 0 : k - 1];
            end
            trial = root_in + bitv;
            if ({1'b0, rem_in} >= trial)
            begin
                sq_rem_next[k]  = 61'(({1'b0, rem_in}) - trial);
                sq_root_next[k] = (root_in >> 1) + bitv;
            end
            else
            begin
                sq_rem_next[k]  = rem_in;
                sq_root_next[k] = root_in >> 1;
            end
        end
    end

    // ---------------- vectoring cordic for the half angle ----------------
    logic               ac_v_reg   [NSTEP];
    ctx_t               ac_ctx_reg [NSTEP];
    logic [30:0]        ac_s30_reg [NSTEP];
    logic signed [33:0] ac_x_reg   [NSTEP];
    logic signed [33:0] ac_y_reg   [NSTEP];
    logic signed [33:0] ac_z_reg   [NSTEP];
    logic signed [33:0] ac_x_next  [NSTEP];
    logic signed [33:0] ac_y_next  [NSTEP];
    logic signed [33:0] ac_z_next  [NSTEP];
    logic [30:0]        sq_s30;

    assign sq_s30 = sq_root_reg[SQ_N - 1][30:0];

    for (genvar i = 0; i < NSTEP; i++)
    begin : g_acos
        logic signed [33:0] x_in, y_in, z_in, ang;
        always_comb
        begin
            ang = $signed({4'd0, qslerp_pkg::atan_q30(i)});
            if (i == 0)
            begin
                x_in = $signed({4'd0, sq_c30_reg[SQ_N - 1]});
                y_in = $signed({3'd0, sq_s30});
                z_in = '0;
            end
            else
            begin
                x_in = ac_x_reg[(i == 0) ? 0 : i - 1];
                y_in = ac_y_reg[(i == 0) ? 0 : i - 1];
                z_in = ac_z_reg[(i == 0) ? 0 : i - 1];
            end
            if (!y_in[33])
            begin
                ac_x_next[i] = x_in + (y_in >>> i);
                ac_y_next[i] = y_in - (x_in >>> i);
                ac_z_next[i] = z_in + ang;
            end
            else
            begin
                ac_x_next[i] = x_in - (y_in >>> i);
                ac_y_next[i] = y_in + (x_in >>> i);
                ac_z_next[i] = z_in - ang;
            end
        end
    end

    // ---------------- scaled angles ----------------
    logic        mu_v_reg;
    ctx_t        mu_ctx_reg;
    logic [30:0] mu_s30_reg;
    logic [46:0] mu_ta_reg, mu_ua_reg;
    logic [30:0] half_ang;
    logic signed [33:0] ac_z_last;

    assign ac_z_last = ac_z_reg[NSTEP - 1];
    assign half_ang  = ac_z_last[33] ? 31'd0 : ac_z_last[30:0];

    // ---------------- rotation cordic, lane 0 for a, lane 1 for b ----------------
    logic               sn_v_reg   [NSTEP];
    ctx_t               sn_ctx_reg [NSTEP];
    logic [30:0]        sn_s30_reg [NSTEP];
    logic signed [33:0] sn_x_reg   [NSTEP][2];
    logic signed [33:0] sn_y_reg   [NSTEP][2];
    logic signed [33:0] sn_z_reg   [NSTEP][2];
    logic signed [33:0] sn_x_next  [NSTEP][2];
    logic signed [33:0] sn_y_next  [NSTEP][2];
    logic signed [33:0] sn_z_next  [NSTEP][2];

    for (genvar i = 0; i < NSTEP; i++)
    begin : g_sin
        for (genvar l = 0; l < 2; l++)
        begin : g_lane
            logic signed [33:0] x_in, y_in, z_in, ang;
            logic [46:0]        prod;
            always_comb
            begin
                ang  = $signed({4'd0, qslerp_pkg::atan_q30(i)});
                prod = (l == 0) ? mu_ua_reg : mu_ta_reg;
                if (i == 0)
                begin
                    x_in = $signed({4'd0, qslerp_pkg::CORDIC_GAIN_INV});
                    y_in = '0;
                    z_in = $signed({2'd0, prod[46:15]});
                end
                else
                begin
                    x_in = sn_x_reg[(i == 0) ? 0 : i - 1][l];
                    y_in = sn_y_reg[(i == 0) ? 0 : i - 1][l];
                    z_in = sn_z_reg[(i == 0) ? 0 : i - 1][l];
                end
                if (!z_in[33])
                begin
                    sn_x_next[i][l] = x_in - (y_in >>> i);
                    sn_y_next[i][l] = y_in + (x_in >>> i);
                    sn_z_next[i][l] = z_in - ang;
                end
                else
                begin
                    sn_x_next[i][l] = x_in + (y_in >>> i);
                    sn_y_next[i][l] = y_in - (x_in >>> i);
                    sn_z_next[i][l] = z_in + ang;
                end
            end
        end
    end

    // ---------------- divider setup ----------------
    logic        dp_v_reg;
    ctx_t        dp_ctx_reg;
    logic [30:0] dp_den_reg, dp_den_next;
    logic [1:0]  dp_ov_reg, dp_ov_next;
    logic [60:0] dp_rem_reg [2];
    logic [60:0] dp_rem_next[2];

    always_comb
    begin
        logic [30:0] num;
        num = '0;
        dp_den_next = (sn_s30_reg[NSTEP - 1] == 31'd0) ? 31'd1 : sn_s30_reg[NSTEP - 1];
        for (int l = 0; l < 2; l++)
        begin
            if (sn_y_reg[NSTEP - 1][l][33])
                num = '0;
            else if (sn_y_reg[NSTEP - 1][l] > $signed({3'd0, qslerp_pkg::ONE_Q30}))
                num = qslerp_pkg::ONE_Q30;
            else
                num = sn_y_reg[NSTEP - 1][l][30:0];
            // quotient would need 33 bits or more
            dp_ov_next[l]  = ({2'd0, num} >= {dp_den_next, 2'd0});
            dp_rem_next[l] = {num, 30'd0};
        end
    end

    // ---------------- restoring dividers ----------------
    logic        dv_v_reg   [DIV_N];
    ctx_t        dv_ctx_reg [DIV_N];
    logic [30:0] dv_den_reg [DIV_N];
    logic [1:0]  dv_ov_reg  [DIV_N];
    logic [60:0] dv_rem_reg [DIV_N][2];
    logic [31:0] dv_q_reg   [DIV_N][2];
    logic [60:0] dv_rem_next[DIV_N][2];
    logic [31:0] dv_q_next  [DIV_N][2];

    for (genvar k = 0; k < DIV_N; k++)
    begin : g_div
        for (genvar l = 0; l < 2; l++)
        begin : g_lane
            logic [60:0] rem_in;
            logic [31:0] q_in;
            logic [30:0] den_in;
            logic [62:0] dsh;
            always_comb
            begin
                if (k == 0)
                begin
                    rem_in = dp_rem_reg[l];
                    q_in   = '0;
                    den_in = dp_den_reg;
                end
                else
                begin
                    rem_in = dv_rem_reg[(k == 0) ? 0 : k - 1][l];
                    q_in   = dv_q_reg[(k == 0) ? 0 : k - 1][l];
                    den_in = dv_den_reg[(k == 0) ? 0 : k - 1];
                end
                dsh = {32'd0, den_in} << (DIV_N - 1 - k);
                dv_q_next[k][l] = q_in;
                if ({2'd0, rem_in} >= dsh)
                begin
                    dv_rem_next[k][l] = 61'({2'd0, rem_in} - dsh);
                    dv_q_next[k][l][DIV_N - 1 - k] = 1'b1;
                end
                else
                begin
                    dv_rem_next[k][l] = rem_in;
                end
            end
        end
    end

    // ---------------- weighting products ----------------
    logic               pr_v_reg;
    ctx_t               pr_ctx_reg;
    logic signed [48:0] pr_a_reg [4];
    logic signed [49:0] pr_b_reg [4];
    logic [31:0]        ratio [2];

    always_comb
    begin
        for (int l = 0; l < 2; l++)
        begin
            if (dv_ov_reg[DIV_N - 1][l] || dv_q_reg[DIV_N - 1][l] > qslerp_pkg::RATIO_LIMIT)
                ratio[l] = qslerp_pkg::RATIO_LIMIT;
            else
                ratio[l] = dv_q_reg[DIV_N - 1][l];
        end
    end

    // ---------------- round, saturate or pass a through, output ----------------
    logic             done_reg;
    qslerp_pkg::out_t result_reg, result_next;

    always_comb
    begin
        logic signed [50:0] acc;
        logic signed [50:0] sh;
        logic [3:0][15:0]   comp;
        acc  = '0;
        sh   = '0;
        comp = '0;
        for (int k = 0; k < 4; k++)
        begin
            acc = 51'(pr_a_reg[k]) + 51'(pr_b_reg[k]) + (51'sd1 <<< 29);
            sh  = acc >>> 30;
            if (pr_ctx_reg.pass)
                comp[k] = pr_ctx_reg.a[k];
            else if (sh > 51'sd32767)
                comp[k] = 16'h7fff;
            else if (sh < -51'sd32768)
                comp[k] = 16'h8000;
            else
                comp[k] = sh[15:0];
        end
        result_next.out_x          = comp[0];
        result_next.out_y          = comp[1];
        result_next.out_z          = comp[2];
        result_next.out_w          = comp[3];
        result_next.passed_through = pr_ctx_reg.pass;
    end

    // ---------------- valid chain ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_v_reg <= 1'b0;
            p1_v_reg <= 1'b0;
            p2_v_reg <= 1'b0;
            p3_v_reg <= 1'b0;
            mu_v_reg <= 1'b0;
            dp_v_reg <= 1'b0;
            pr_v_reg <= 1'b0;
            done_reg <= 1'b0;
            for (int k = 0; k < SQ_N; k++)
                sq_v_reg[k] <= 1'b0;
            for (int i = 0; i < NSTEP; i++)
            begin
                ac_v_reg[i] <= 1'b0;
                sn_v_reg[i] <= 1'b0;
            end
            for (int k = 0; k < DIV_N; k++)
                dv_v_reg[k] <= 1'b0;
        end
        else
        begin
            in_v_reg <= start;
            p1_v_reg <= in_v_reg;
            p2_v_reg <= p1_v_reg;
            p3_v_reg <= p2_v_reg;
            sq_v_reg[0] <= p3_v_reg;
            for (int k = 1; k < SQ_N; k++)
                sq_v_reg[k] <= sq_v_reg[k - 1];
            ac_v_reg[0] <= sq_v_reg[SQ_N - 1];
            for (int i = 1; i < NSTEP; i++)
                ac_v_reg[i] <= ac_v_reg[i - 1];
            mu_v_reg <= ac_v_reg[NSTEP - 1];
            sn_v_reg[0] <= mu_v_reg;
            for (int i = 1; i < NSTEP; i++)
                sn_v_reg[i] <= sn_v_reg[i - 1];
            dp_v_reg <= sn_v_reg[NSTEP - 1];
            dv_v_reg[0] <= dp_v_reg;
            for (int k = 1; k < DIV_N; k++)
                dv_v_reg[k] <= dv_v_reg[k - 1];
            pr_v_reg <= dv_v_reg[DIV_N - 1];
            done_reg <= pr_v_reg;
        end
    end

    // ---------------- data path registers ----------------
    always_ff @(posedge clk)
    begin
        in_ctx_reg <= in_ctx_next;

        p1_ctx_reg <= in_ctx_reg;
        for (int k = 0; k < 4; k++)
            p1_prod_reg[k] <= $signed(in_ctx_reg.a[k]) * $signed(in_ctx_reg.b[k][15:0]);

        p2_ctx_reg <= p2_ctx_next;
        p2_c30_reg <= p2_c30_next;

        p3_ctx_reg <= p2_ctx_reg;
        p3_c30_reg <= p2_c30_reg;
        p3_sq_reg  <= p2_c30_reg * p2_c30_reg;

        sq_ctx_reg[0] <= p3_ctx_reg;
        sq_c30_reg[0] <= p3_c30_reg;
        for (int k = 1; k < SQ_N; k++)
        begin
            sq_ctx_reg[k] <= sq_ctx_reg[k - 1];
            sq_c30_reg[k] <= sq_c30_reg[k - 1];
        end
        for (int k = 0; k < SQ_N; k++)
        begin
            sq_rem_reg[k]  <= sq_rem_next[k];
            sq_root_reg[k] <= sq_root_next[k];
        end

        ac_ctx_reg[0] <= sq_ctx_reg[SQ_N - 1];
        ac_s30_reg[0] <= sq_s30;
        for (int i = 1; i < NSTEP; i++)
        begin
            ac_ctx_reg[i] <= ac_ctx_reg[i - 1];
            ac_s30_reg[i] <= ac_s30_reg[i - 1];
        end
        for (int i = 0; i < NSTEP; i++)
        begin
            ac_x_reg[i] <= ac_x_next[i];
            ac_y_reg[i] <= ac_y_next[i];
            ac_z_reg[i] <= ac_z_next[i];
        end

        mu_ctx_reg <= ac_ctx_reg[NSTEP - 1];
        mu_s30_reg <= ac_s30_reg[NSTEP - 1];
        mu_ta_reg  <= half_ang * ac_ctx_reg[NSTEP - 1].t;
        mu_ua_reg  <= half_ang * 16'(17'd32768 - {1'b0, ac_ctx_reg[NSTEP - 1].t});

        sn_ctx_reg[0] <= mu_ctx_reg;
        sn_s30_reg[0] <= mu_s30_reg;
        for (int i = 1; i < NSTEP; i++)
        begin
            sn_ctx_reg[i] <= sn_ctx_reg[i - 1];
            sn_s30_reg[i] <= sn_s30_reg[i - 1];
        end
        for (int i = 0; i < NSTEP; i++)
        begin
            for (int l = 0; l < 2; l++)
            begin
                sn_x_reg[i][l] <= sn_x_next[i][l];
                sn_y_reg[i][l] <= sn_y_next[i][l];
                sn_z_reg[i][l] <= sn_z_next[i][l];
            end
        end

        dp_ctx_reg <= sn_ctx_reg[NSTEP - 1];
        dp_den_reg <= dp_den_next;
        dp_ov_reg  <= dp_ov_next;
        for (int l = 0; l < 2; l++)
            dp_rem_reg[l] <= dp_rem_next[l];

        dv_ctx_reg[0] <= dp_ctx_reg;
        dv_den_reg[0] <= dp_den_reg;
        dv_ov_reg[0]  <= dp_ov_reg;
        for (int k = 1; k < DIV_N; k++)
        begin
            dv_ctx_reg[k] <= dv_ctx_reg[k - 1];
            dv_den_reg[k] <= dv_den_reg[k - 1];
            dv_ov_reg[k]  <= dv_ov_reg[k - 1];
        end
        for (int k = 0; k < DIV_N; k++)
        begin
            for (int l = 0; l < 2; l++)
            begin
                dv_rem_reg[k][l] <= dv_rem_next[k][l];
                dv_q_reg[k][l]   <= dv_q_next[k][l];
            end
        end

        pr_ctx_reg <= dv_ctx_reg[DIV_N - 1];
        for (int k = 0; k < 4; k++)
        begin
            pr_a_reg[k] <= $signed(dv_ctx_reg[DIV_N - 1].a[k]) * $signed({1'b0, ratio[0]});
            pr_b_reg[k] <= $signed(dv_ctx_reg[DIV_N - 1].b[k]) * $signed({1'b0, ratio[1]});
        end

        result_reg <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule
